// ===== design/mcps_pkg.sv =====
// ----------------------------------------------------------------------------
// mcps_pkg
// Shared types and constants of the controller-change pattern sequencer.
// ----------------------------------------------------------------------------
package mcps_pkg;

   localparam int NUM_PATTERNS_DEF    = 8;
   localparam int PATTERN_STEPS_DEF   = 256;
   localparam int BAR_TICKS_DEF       = 256;
   localparam int MAX_STEP_LENGTH_DEF = 16;

   // only the first eight patterns can be active
   localparam int MAX_PLAYABLE = 8;

   localparam int CHAN_W      = 4;
   localparam int CC_W        = 7;
   localparam int LEN_FIELD_W = 5;
   localparam int LENS_W      = 40;
   localparam int CTLS_W      = 56;
   localparam int CSR_W       = 56;
   localparam int CSR_IDX_W   = 2;

   localparam logic [LENS_W-1:0] STEP_LENGTHS_RESET = 40'd35468117025;

   localparam logic [CSR_IDX_W-1:0] CSR_MIDI_CHANNEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LENGTHS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROLLERS  = 2'd2;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_RESET  = 3'd3,
      CMD_WRITE  = 3'd4,
      CMD_ACTIVE = 3'd5
   } cmd_code_type;

   typedef struct packed {
      logic [2:0] command;
      logic [2:0] pattern_select;
      logic [7:0] entry_position;
      logic [6:0] entry_value;
      logic [7:0] active_mask;
   } req_type;

   typedef struct packed {
      logic [3:0] channel_out;
      logic [6:0] controller_out;
      logic [6:0] value_out;
      logic [2:0] source_pattern;
      logic       last_of_tick;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] midi_channel;
      logic [LENS_W-1:0] step_lengths;
      logic [CTLS_W-1:0] controllers;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      req_type word;
   } qhead_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

// ===== design/midi_cc_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// midi_cc_pattern_sequencer_top
// Eight-pattern controller-change sequencer with interpolated playback.
// ----------------------------------------------------------------------------
// Commands enter on the req_ channel (valid/ready), control change words
// leave on the rsp_ channel (valid/ready); csr_ is a plain register write.
// A front queue of two words takes commands while the executor is busy;
// codes six and seven and out-of-range entry writes are dropped there.
// Reset clears all control state and then sweeps the pattern memory to
// zero, one entry per cycle, over NUM_PATTERNS * PATTERN_STEPS entries
// (2048 by default) with req_ready low; csr writes are taken throughout.
// A tick while running walks the active patterns: per active pattern there
// are two memory reads on the single read port and a bit-serial division
// of an 11-bit dividend. Results leave through an output register; the
// word of a pattern is held until the next one (or the end of the tick)
// marks whether it is last. While rsp_ready is low the executor waits
// when both the held word and the output register are full; the front
// queue keeps taking commands until it holds two words.
// ----------------------------------------------------------------------------
module midi_cc_pattern_sequencer_top #(
   parameter int NUM_PATTERNS    = mcps_pkg::NUM_PATTERNS_DEF,
   parameter int PATTERN_STEPS   = mcps_pkg::PATTERN_STEPS_DEF,
   parameter int BAR_TICKS       = mcps_pkg::BAR_TICKS_DEF,
   parameter int MAX_STEP_LENGTH = mcps_pkg::MAX_STEP_LENGTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mcps_pkg::req_type                 req_word,
   input  logic                              req_valid,
   output logic                              req_ready,
   output mcps_pkg::rsp_type                 rsp_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              csr_we,
   input  logic [mcps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mcps_pkg::CSR_W-1:0]        csr_wdata
);
   import mcps_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   qhead_type       head;
   back_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIDI_CHANNEL: cfg_in.midi_channel = csr_wdata[CHAN_W-1:0];
            CSR_STEP_LENGTHS: cfg_in.step_lengths = csr_wdata[LENS_W-1:0];
            CSR_CONTROLLERS:  cfg_in.controllers  = csr_wdata[CTLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.midi_channel <= '0;
         cfg_ff.step_lengths <= STEP_LENGTHS_RESET;
         cfg_ff.controllers  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcps_front #(
      .NUM_PATTERNS  (NUM_PATTERNS),
      .PATTERN_STEPS (PATTERN_STEPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .head      (head)
   );

   mcps_back #(
      .NUM_PATTERNS    (NUM_PATTERNS),
      .PATTERN_STEPS   (PATTERN_STEPS),
      .BAR_TICKS       (BAR_TICKS),
      .MAX_STEP_LENGTH (MAX_STEP_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .status    (status),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// ===== design/mcps_front.sv =====
// ----------------------------------------------------------------------------
// mcps_front
// Accepts command words, drops spare codes and out-of-range entry writes, queues the rest.
// ----------------------------------------------------------------------------
module mcps_front #(
   parameter int NUM_PATTERNS  = mcps_pkg::NUM_PATTERNS_DEF,
   parameter int PATTERN_STEPS = mcps_pkg::PATTERN_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mcps_pkg::req_type        req_word,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mcps_pkg::back_status_type status,
   output mcps_pkg::qhead_type      head
);
   import mcps_pkg::*;

   localparam int QDEPTH = 2;

   req_type    q_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep;
   logic       push;

   always_comb begin
      keep = 1'b0;
      unique case (req_word.command)
         CMD_TICK, CMD_START, CMD_STOP, CMD_RESET, CMD_ACTIVE: keep = 1'b1;
         CMD_WRITE: begin
            keep = (int'(req_word.pattern_select) < NUM_PATTERNS) &&
                   (int'(req_word.entry_position) < PATTERN_STEPS);
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != 2'(QDEPTH)) && !status.clearing;
   assign push      = req_valid && req_ready && keep;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = status.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_word;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.word  = q_ff[rd_ptr_ff];

endmodule

// ===== design/mcps_back.sv =====
// ----------------------------------------------------------------------------
// mcps_back
// Executes queued commands: pattern memory, transport state, per-tick walk
// over the patterns with a bit-serial divider, and the result register.
// ----------------------------------------------------------------------------
module mcps_back #(
   parameter int NUM_PATTERNS    = mcps_pkg::NUM_PATTERNS_DEF,
   parameter int PATTERN_STEPS   = mcps_pkg::PATTERN_STEPS_DEF,
   parameter int BAR_TICKS       = mcps_pkg::BAR_TICKS_DEF,
   parameter int MAX_STEP_LENGTH = mcps_pkg::MAX_STEP_LENGTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mcps_pkg::cfg_type         cfg,
   input  mcps_pkg::qhead_type       head,
   output mcps_pkg::back_status_type status,
   output mcps_pkg::rsp_type         rsp_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready
);
   import mcps_pkg::*;

   localparam int PLAYABLE = (NUM_PATTERNS < MAX_PLAYABLE) ? NUM_PATTERNS : MAX_PLAYABLE;
   localparam int PIDX_W   = (PLAYABLE > 1) ? $clog2(PLAYABLE) : 1;
   localparam int DEPTH    = NUM_PATTERNS * PATTERN_STEPS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int STEP_W   = $clog2(PATTERN_STEPS);
   localparam int SUB_W    = (MAX_STEP_LENGTH > 1) ? $clog2(MAX_STEP_LENGTH) : 1;
   localparam int LEN_W    = $clog2(MAX_STEP_LENGTH + 1);
   localparam int BAR_W    = (BAR_TICKS > 1) ? $clog2(BAR_TICKS) : 1;
   localparam int DVD_W    = CC_W + SUB_W;
   localparam int CNT_W    = $clog2(DVD_W + 1);
   localparam int SV_W     = DVD_W + 2;
   localparam int PCNT_W   = 4;
   localparam int MSG_W    = CHAN_W + 2 * CC_W;

   localparam logic [ADDR_W-1:0] STEPS_A = ADDR_W'(PATTERN_STEPS);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_RD_CUR = 8'b0000_1000,
      S_RD_NXT = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_CMP    = 8'b0100_0000,
      S_FLUSH  = 8'b1000_0000
   } state_type;

   function automatic logic [LEN_W-1:0] len_of(logic [LENS_W-1:0] lens,
                                                logic [PIDX_W-1:0] idx);
      logic [LEN_FIELD_W-1:0] f;
      logic [LEN_W-1:0]       len;
      f = LEN_FIELD_W'(lens >> (LEN_FIELD_W * int'(idx)));
      if (f == '0) len = LEN_W'(1);
      else if (int'(f) > MAX_STEP_LENGTH) len = LEN_W'(MAX_STEP_LENGTH);
      else len = LEN_W'(f);
      return len;
   endfunction

   function automatic logic [CC_W-1:0] ctl_of(logic [CTLS_W-1:0] ctls,
                                              logic [PIDX_W-1:0] idx);
      return CC_W'(ctls >> (CC_W * int'(idx)));
   endfunction

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              running_ff, running_in;
   logic              keep_ff, keep_in;
   logic [BAR_W-1:0]  bar_ff, bar_in;
   logic [7:0]        active_ff, active_in;
   logic [SUB_W-1:0]  sub_ff [PLAYABLE];
   logic [SUB_W-1:0]  sub_in [PLAYABLE];
   logic [STEP_W-1:0] step_ff [PLAYABLE];
   logic [STEP_W-1:0] step_in [PLAYABLE];
   logic [MSG_W-1:0]  last_ff [PLAYABLE];
   logic [MSG_W-1:0]  last_in [PLAYABLE];
   logic [PCNT_W-1:0] p_ff, p_in;
   logic [CC_W-1:0]   a_ff, a_in;
   logic              neg_ff, neg_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [CC_W-1:0]   pattern_mem [DEPTH];
   logic [CC_W-1:0]   mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CC_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   always_comb begin
      logic [PIDX_W-1:0] pi;
      logic [STEP_W-1:0] cur;
      logic [STEP_W-1:0] nxt;
      logic [LEN_W-1:0]  len_cur;
      logic              out_free;
      logic              stop_now;
      logic [CC_W-1:0]   mag;
      logic [LEN_W:0]    rem_sh;
      logic              qbit;
      logic signed [SV_W-1:0] sv;
      logic [CC_W-1:0]   v;
      logic [CC_W-1:0]   ctl;
      logic [MSG_W-1:0]  msg;
      logic [LEN_W:0]    sub_nx;

      pi       = p_ff[PIDX_W-1:0];
      cur      = step_ff[pi];
      nxt      = (cur == STEP_W'(PATTERN_STEPS - 1)) ? '0 : cur + 1'b1;
      len_cur  = len_of(cfg.step_lengths, pi);
      out_free = !out_valid_ff || rsp_ready;
      stop_now = (bar_ff == '0) && !keep_ff;
      mag      = (mem_rdata_ff < a_ff) ? (a_ff - mem_rdata_ff) : (mem_rdata_ff - a_ff);
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      qbit     = (rem_sh >= {1'b0, len_cur});
      sv       = neg_ff ? (SV_W'(a_ff) - SV_W'(dvd_ff)) : (SV_W'(a_ff) + SV_W'(dvd_ff));
      if (sv < 0) v = '0;
      else if (sv > 127) v = 7'd127;
      else v = sv[CC_W-1:0];
      ctl      = ctl_of(cfg.controllers, pi);
      msg      = {cfg.midi_channel, ctl, v};
      sub_nx   = '0;

      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      running_in      = running_ff;
      keep_in         = keep_ff;
      bar_in          = bar_ff;
      active_in       = active_ff;
      sub_in          = sub_ff;
      step_in         = step_ff;
      last_in         = last_ff;
      p_in            = p_ff;
      a_in            = a_ff;
      neg_in          = neg_ff;
      dvd_in          = dvd_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      pend_valid_in   = pend_valid_ff;
      pend_in         = pend_ff;
      out_valid_in    = out_valid_ff;
      out_in          = out_ff;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      mem_wdata       = '0;
      mem_raddr       = '0;
      status.pop      = 1'b0;
      status.clearing = (state_ff == S_CLEAR);

      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) state_in = S_IDLE;
            else clr_addr_in = clr_addr_ff + 1'b1;
         end
         S_IDLE: begin
            if (head.valid) begin
               status.pop = 1'b1;
               unique case (head.word.command)
                  CMD_TICK: begin
                     if (stop_now) begin
                        running_in = 1'b0;
                        keep_in    = 1'b0;
                        for (int k = 0; k < PLAYABLE; k++) begin
                           sub_in[k]  = '0;
                           step_in[k] = '0;
                        end
                     end
                     if (running_ff && !stop_now) begin
                        p_in     = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_START: begin
                     running_in = 1'b1;
                     keep_in    = 1'b1;
                  end
                  CMD_STOP: keep_in = 1'b0;
                  CMD_RESET: begin
                     running_in = 1'b0;
                     keep_in    = 1'b0;
                     for (int k = 0; k < PLAYABLE; k++) begin
                        sub_in[k]  = '0;
                        step_in[k] = '0;
                     end
                  end
                  CMD_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(head.word.pattern_select) * STEPS_A +
                                 ADDR_W'(head.word.entry_position);
                     mem_wdata = head.word.entry_value;
                  end
                  CMD_ACTIVE: active_in = head.word.active_mask;
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (p_ff >= PCNT_W'(PLAYABLE)) begin
               state_in = S_FLUSH;
            end else if (active_ff[p_ff[2:0]]) begin
               mem_raddr = ADDR_W'(pi) * STEPS_A + ADDR_W'(cur);
               state_in  = S_RD_CUR;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         S_RD_CUR: begin
            a_in      = mem_rdata_ff;
            mem_raddr = ADDR_W'(pi) * STEPS_A + ADDR_W'(nxt);
            state_in  = S_RD_NXT;
         end
         S_RD_NXT: begin
            neg_in   = (mem_rdata_ff < a_ff);
            dvd_in   = DVD_W'(mag) * DVD_W'(sub_ff[pi]);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in = qbit ? LEN_W'(rem_sh - {1'b0, len_cur}) : LEN_W'(rem_sh);
            dvd_in = {dvd_ff[DVD_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) state_in = S_CMP;
         end
         S_CMP: begin
            if (msg == last_ff[pi]) begin
               p_in     = p_ff + 1'b1;
               state_in = S_SCAN;
            end else if (!pend_valid_ff || out_free) begin
               // the held word is not the last of the tick
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_in       = pend_ff;
               end
               pend_valid_in          = 1'b1;
               pend_in.channel_out    = cfg.midi_channel;
               pend_in.controller_out = ctl;
               pend_in.value_out      = v;
               pend_in.source_pattern = 3'(pi);
               pend_in.last_of_tick   = 1'b0;
               last_in[pi]            = msg;
               p_in                   = p_ff + 1'b1;
               state_in               = S_SCAN;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in        = 1'b1;
                  out_in              = pend_ff;
                  out_in.last_of_tick = 1'b1;
                  pend_valid_in       = 1'b0;
               end
               bar_in = (bar_ff == BAR_W'(BAR_TICKS - 1)) ? '0 : bar_ff + 1'b1;
               for (int k = 0; k < PLAYABLE; k++) begin
                  if (active_ff[k]) begin
                     sub_nx = (LEN_W + 1)'(sub_ff[k]) + 1'b1;
                     if (sub_nx >= (LEN_W + 1)'(len_of(cfg.step_lengths, PIDX_W'(k)))) begin
                        sub_in[k]  = '0;
                        step_in[k] = (step_ff[k] == STEP_W'(PATTERN_STEPS - 1)) ?
                                     '0 : step_ff[k] + 1'b1;
                     end else begin
                        sub_in[k] = SUB_W'(sub_nx);
                     end
                  end else begin
                     sub_in[k]  = '0;
                     step_in[k] = '0;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         running_ff    <= 1'b0;
         keep_ff       <= 1'b0;
         bar_ff        <= '0;
         active_ff     <= '0;
         p_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int k = 0; k < PLAYABLE; k++) begin
            sub_ff[k]  <= '0;
            step_ff[k] <= '0;
            last_ff[k] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         running_ff    <= running_in;
         keep_ff       <= keep_in;
         bar_ff        <= bar_in;
         active_ff     <= active_in;
         p_ff          <= p_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         sub_ff        <= sub_in;
         step_ff       <= step_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) pattern_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= pattern_mem[mem_raddr];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_word        = out_ff;

endmodule

// ===== design/mcps_checker.sv =====
// ----------------------------------------------------------------------------
// mcps_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mcps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input mcps_pkg::rsp_type rsp_word,
   input logic              rsp_valid,
   input logic              rsp_ready
);
   import mcps_pkg::*;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // no result straight out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // memory sweep keeps commands out after reset
   assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("req ready during memory clear");

endmodule

bind midi_cc_pattern_sequencer_top mcps_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_word  (rsp_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

// ===== bench/midi_cc_pattern_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// midi_cc_pattern_sequencer_top_tb
// Self-checking bench for the controller-change pattern sequencer: drives
// command words and register writes, predicts every control change word
// from an internal model of the sequencer and checks each word leaving it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module midi_cc_pattern_sequencer_top_tb;
   import mcps_pkg::*;

   localparam logic [2:0]           CMD_SPARE_6 = 3'd6;
   localparam logic [2:0]           CMD_SPARE_7 = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;

   // ---------------------------------------------------------------------
   // sequencer model and queue of control change words still to come
   // ---------------------------------------------------------------------
   class cc_scoreboard;
      logic [6:0]  pattern_mem [0:2047];
      bit          playing;
      bit          keep_playing;
      int          bar_pos;
      logic [7:0]  active;
      int          sub_pos [8];
      int          step_pos [8];
      logic [17:0] last_msg [8];
      logic [3:0]  channel;
      logic [39:0] lengths;
      logic [55:0] controllers;
      rsp_type     cc_due [$];
      int          errors;

      function void clear_positions();
         playing = 0;
         keep_playing = 0;
         for (int p = 0; p < 8; p++) begin
            sub_pos[p] = 0;
            step_pos[p] = 0;
         end
      endfunction

      function void power_on();
         channel = '0;
         lengths = STEP_LENGTHS_RESET;
         controllers = '0;
         for (int i = 0; i < 2048; i++) pattern_mem[i] = '0;
         clear_positions();
         bar_pos = 0;
         active = '0;
         for (int p = 0; p < 8; p++) last_msg[p] = '0;
         errors = 0;
      endfunction

      function int length_of(int p);
         int n;
         n = lengths[5*p +: 5];
         if (n < 1) n = 1;
         if (n > MAX_STEP_LENGTH_DEF) n = MAX_STEP_LENGTH_DEF;
         return n;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] d);
         case (idx)
            CSR_MIDI_CHANNEL: channel = d[3:0];
            CSR_STEP_LENGTHS: lengths = d[39:0];
            CSR_CONTROLLERS:  controllers = d[55:0];
            default: ;
         endcase
      endfunction

      function void note_word(req_type w);
         int a, b, v, cur, nxt, n;
         logic [6:0] ctl;
         rsp_type r;
         n = 0;
         case (w.command)
            CMD_TICK: begin
               if (bar_pos == 0 && !keep_playing) clear_positions();
               if (playing) begin
                  for (int p = 0; p < MAX_PLAYABLE; p++) begin
                     if (!active[p]) continue;
                     cur = step_pos[p];
                     nxt = (cur + 1) % PATTERN_STEPS_DEF;
                     a = pattern_mem[p*PATTERN_STEPS_DEF + cur];
                     b = pattern_mem[p*PATTERN_STEPS_DEF + nxt];
                     v = a + ((b - a) * sub_pos[p]) / length_of(p);
                     if (v < 0) v = 0;
                     if (v > 127) v = 127;
                     ctl = controllers[7*p +: 7];
                     if ({channel, ctl, 7'(v)} != last_msg[p]) begin
                        last_msg[p] = {channel, ctl, 7'(v)};
                        r.channel_out = channel;
                        r.controller_out = ctl;
                        r.value_out = 7'(v);
                        r.source_pattern = 3'(p);
                        r.last_of_tick = 1'b0;
                        cc_due.push_back(r);
                        n++;
                     end
                  end
                  if (n > 0) cc_due[$].last_of_tick = 1'b1;
                  bar_pos = (bar_pos + 1) % BAR_TICKS_DEF;
                  for (int p = 0; p < 8; p++) begin
                     if (active[p]) begin
                        sub_pos[p]++;
                        if (sub_pos[p] >= length_of(p)) begin
                           sub_pos[p] = 0;
                           step_pos[p] = (step_pos[p] + 1) % PATTERN_STEPS_DEF;
                        end
                     end else begin
                        sub_pos[p] = 0;
                        step_pos[p] = 0;
                     end
                  end
               end
            end
            CMD_START: begin
               playing = 1;
               keep_playing = 1;
            end
            CMD_STOP:   keep_playing = 0;
            CMD_RESET:  clear_positions();
            CMD_WRITE:  pattern_mem[w.pattern_select*PATTERN_STEPS_DEF + w.entry_position]
                           = w.entry_value;
            CMD_ACTIVE: active = w.active_mask;
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (cc_due.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         want = cc_due.pop_front();
         if (got.channel_out != want.channel_out)
            report($sformatf("channel %0d, want %0d", got.channel_out, want.channel_out));
         if (got.controller_out != want.controller_out)
            report($sformatf("controller %0d, want %0d",
                             got.controller_out, want.controller_out));
         if (got.value_out != want.value_out)
            report($sformatf("value %0d, want %0d", got.value_out, want.value_out));
         if (got.source_pattern != want.source_pattern)
            report($sformatf("pattern %0d, want %0d",
                             got.source_pattern, want.source_pattern));
         if (got.last_of_tick != want.last_of_tick)
            report($sformatf("last flag %0b, want %0b",
                             got.last_of_tick, want.last_of_tick));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   req_type              req_word;
   logic                 req_valid;
   logic                 req_ready;
   rsp_type              rsp_word;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   cc_scoreboard sb;
   int tx_idle_pct;
   int rx_idle_pct;
   int quiet_cycles;

   midi_cc_pattern_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_word);
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("midi_cc_pattern_sequencer_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task send_word(req_type w);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_word(w);
   endtask

   task send_cmd(cmd_code_type c, logic [2:0] sel, logic [7:0] pos, logic [6:0] val,
                 logic [7:0] mask);
      req_type w;
      w.command = c;
      w.pattern_select = sel;
      w.entry_position = pos;
      w.entry_value = val;
      w.active_mask = mask;
      send_word(w);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] d);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, d);
   endtask

   // wait for every expected word, then let a silent tick finish
   task drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.cc_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task random_word();
      req_type w;
      int pick;
      w = req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         w.command = CMD_TICK;
      end else if (pick < 75) begin
         w.command = CMD_WRITE;
         if ($urandom_range(0, 3) != 0) w.entry_position = 8'($urandom_range(0, 12));
      end else if (pick < 81) begin
         w.command = CMD_ACTIVE;
      end else if (pick < 88) begin
         w.command = CMD_START;
      end else if (pick < 93) begin
         w.command = CMD_STOP;
      end else if (pick < 96) begin
         w.command = CMD_RESET;
      end else begin
         w.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      send_word(w);
   endtask

   initial begin
      req_word = '0;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_cycles = 0;
      tx_idle_pct = 9;
      rx_idle_pct = 72;
      sb = new();
      sb.power_on();
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first setting: top channel, odd lengths incl. zero and oversize
      write_reg(CSR_MIDI_CHANNEL, 56'd15);
      write_reg(CSR_STEP_LENGTHS,
                56'({5'd31, 5'd16, 5'd0, 5'd1, 5'd2, 5'd3, 5'd17, 5'd5}));
      write_reg(CSR_CONTROLLERS, 56'({$urandom, $urandom}));
      write_reg(CSR_SPARE, 56'({$urandom, $urandom}));

      // directed part
      send_cmd(CMD_WRITE, 3'd0, 8'd0, 7'd127, 8'h00);
      send_cmd(CMD_WRITE, 3'd0, 8'd255, 7'd0, 8'hff);
      send_cmd(CMD_WRITE, 3'd7, 8'd1, 7'd127, 8'h00);
      send_cmd(CMD_WRITE, 3'd3, 8'd0, 7'd64, 8'h55);
      send_cmd(CMD_WRITE, 3'd3, 8'd1, 7'd0, 8'haa);
      send_cmd(CMD_TICK, 3'd7, 8'hff, 7'h7f, 8'hff);
      send_cmd(CMD_ACTIVE, 3'd0, 8'd0, 7'd0, 8'hff);
      send_cmd(CMD_START, 3'd0, 8'd0, 7'd0, 8'h00);
      repeat (4) send_cmd(CMD_TICK, 3'd0, 8'd0, 7'd0, 8'h00);
      send_cmd(CMD_STOP, 3'd0, 8'd0, 7'd0, 8'h00);
      repeat (2) send_cmd(CMD_TICK, 3'd5, 8'd3, 7'd9, 8'h0f);
      send_word(req_type'({CMD_SPARE_6, 3'd7, 8'hff, 7'h7f, 8'hff}));
      send_word(req_type'({CMD_SPARE_7, 3'd0, 8'h00, 7'h00, 8'h00}));
      send_cmd(CMD_RESET, 3'd0, 8'd0, 7'd0, 8'h00);
      send_cmd(CMD_TICK, 3'd0, 8'd0, 7'd0, 8'h00);
      send_cmd(CMD_START, 3'd0, 8'd0, 7'd0, 8'h00);
      send_cmd(CMD_ACTIVE, 3'd0, 8'd0, 7'd0, 8'h00);
      send_cmd(CMD_TICK, 3'd0, 8'd0, 7'd0, 8'h00);
      send_cmd(CMD_ACTIVE, 3'd0, 8'd0, 7'd0, 8'h89);
      repeat (3) send_cmd(CMD_TICK, 3'd0, 8'd0, 7'd0, 8'h00);

      for (int phase = 0; phase < 3; phase++) begin
         drain();
         tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 72 : 0;
         rx_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 9 : 0;
         if (phase == 1) begin
            // shortest steps, all-ones controller numbers
            write_reg(CSR_MIDI_CHANNEL, 56'd0);
            write_reg(CSR_STEP_LENGTHS, 56'd0);
            write_reg(CSR_CONTROLLERS, {56{1'b1}});
         end else if (phase == 2) begin
            write_reg(CSR_MIDI_CHANNEL, 56'($urandom));
            write_reg(CSR_STEP_LENGTHS, 56'({$urandom, $urandom}));
            write_reg(CSR_CONTROLLERS, 56'({$urandom, $urandom}));
         end
         send_cmd(CMD_ACTIVE, 3'd0, 8'd0, 7'd0, 8'($urandom | 1));
         send_cmd(CMD_START, 3'd0, 8'd0, 7'd0, 8'h00);
         repeat (90) random_word();
      end

      drain();
      if (sb.errors == 0) begin
         $display("midi_cc_pattern_sequencer_top_tb: clean");
      end else begin
         $display("midi_cc_pattern_sequencer_top_tb: errors");
      end
      $finish;
   end

endmodule
